// ----- design/abes_pkg.sv -----
// ----------------------------------------------------------------------------
// abes_pkg: shared types and constants for the ADPCM block encoder search
// Filter tables, block sizes and controller/datapath command structs.
// ----------------------------------------------------------------------------
package abes_pkg;

    localparam int NSAMP   = 28;
    localparam int NBYTES  = 16;
    localparam int NFILT   = 5;
    localparam int NSHIFT  = 13;

    // controller to datapath commands
    typedef struct packed {
        logic       store;      // write incoming sample
        logic [4:0] wr_idx;
        logic       trial_init; // load history for a new trial
        logic       run;        // process one sample of current trial
        logic [4:0] smp_idx;
        logic [2:0] filt;
        logic [3:0] shft;
        logic       trial_end;  // compare trial error, keep winner
        logic       search_init;
        logic       commit;     // commit winning history
        logic       emit;       // output phase flag, unused by datapath
        logic [3:0] byte_idx;
    } abes_cmd_t;

    typedef struct packed {
        logic [7:0] byte_val;
    } abes_sts_t;

    function automatic logic signed [7:0] filt_a(input logic [2:0] f);
        case (f)
            3'd1:    filt_a = 8'sd60;
            3'd2:    filt_a = 8'sd115;
            3'd3:    filt_a = 8'sd98;
            3'd4:    filt_a = 8'sd122;
            default: filt_a = 8'sd0;
        endcase
    endfunction

    function automatic logic signed [7:0] filt_b(input logic [2:0] f);
        case (f)
            3'd2:    filt_b = -8'sd52;
            3'd3:    filt_b = -8'sd55;
            3'd4:    filt_b = -8'sd60;
            default: filt_b = 8'sd0;
        endcase
    endfunction

endpackage

// ----- design/adpcm_block_encoder_search_unit.sv -----
// ----------------------------------------------------------------------------
// adpcm_block_encoder_search_unit: 28-sample ADPCM block encoder with search
// Collects samples, tries all filter/shift pairs, emits a 16-byte block.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | sample, block_flags
//  out     | out_valid/out_ready | out_byte, byte_index, last_byte
//
//  Items 1..27 of a block are stored as they arrive. The 28th starts a search
//  of 65 trials (one sample-trial per cycle in the shared quantise/reconstruct
//  unit), then 16 output bytes, one per cycle unless out_ready is low.
//  Input is held off during search and emit. Reset clears history and
//  sample count. A stalled output holds its byte.
module adpcm_block_encoder_search_unit
    import abes_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] sample,
    input  logic [7:0]  block_flags,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic [3:0]  byte_index,
    output logic        last_byte
);

    abes_cmd_t cmd;
    abes_sts_t sts;
    logic      emit_last;

    abes_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .emit_last (emit_last)
    );

    abes_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample      ($signed(sample)),
        .block_flags (block_flags),
        .sts         (sts)
    );

    assign out_byte   = sts.byte_val;
    assign byte_index = cmd.byte_idx;
    assign last_byte  = emit_last;

endmodule

// ----- design/abes_datapath.sv -----
// ----------------------------------------------------------------------------
// abes_datapath: sample store, one sample-trial per cycle, winner tracking
// Predict, quantise and reconstruct combinationally; the squared error of each
// sample-trial is registered and added to the trial sum in the next cycle.
// ----------------------------------------------------------------------------
module abes_datapath
    import abes_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  abes_cmd_t         cmd,
    input  logic signed [15:0] sample,
    input  logic [7:0]        block_flags,
    output abes_sts_t         sts
);

    logic signed [15:0] store_mem [NSAMP];
    logic [3:0]         nib_trial [NSAMP];
    logic [3:0]         nib_win   [NSAMP];
    logic signed [15:0] last_reg, prev_reg, last_next, prev_next;   // trial history
    logic signed [15:0] hlast_reg, hprev_reg;                        // committed
    logic signed [15:0] blast_reg, bprev_reg;                        // best of search
    logic [36:0]        err_reg, err_next;
    logic [36:0]        werr_reg;
    logic [2:0]         bf_reg;
    logic [3:0]         bs_reg;
    logic [7:0]         flags_reg;
    logic signed [15:0] s_cur_reg;                                   // sample being tried
    logic signed [16:0] d_reg;                                       // error awaiting square
    logic [4:0]         rd_idx;

    // prefetch address: sample 0 on trial start, else the one after the current
    assign rd_idx = cmd.trial_init ? cmd.smp_idx
                  : ((cmd.smp_idx == 5'(NSAMP - 1)) ? 5'd0 : cmd.smp_idx + 5'd1);

    // sample store
    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            store_mem[cmd.wr_idx] <= sample;
            if (cmd.wr_idx == 5'(NSAMP - 1))
                flags_reg <= block_flags;
        end
        if (cmd.trial_init || cmd.run)
            s_cur_reg <= store_mem[rd_idx];
    end

    // one sample-trial: predict, quantise, reconstruct
    logic signed [15:0] s_cur;
    logic signed [25:0] pacc;
    logic signed [19:0] pred;
    logic [3:0]         amt;
    logic signed [21:0] resid;
    logic signed [21:0] q_raw;
    logic signed [4:0]  q;
    logic signed [22:0] rec_w;
    logic signed [15:0] rec;
    logic signed [16:0] d;
    logic [33:0]        sq;
    always_comb
    begin
        s_cur = s_cur_reg;
        pacc  = 26'(last_reg * filt_a(cmd.filt)) + 26'(prev_reg * filt_b(cmd.filt)) + 26'sd32;
        pred  = 20'(pacc >>> 6);
        amt   = 4'd12 - cmd.shft;
        resid = 22'(s_cur) - 22'(pred)
              + ((amt != 4'd0) ? (22'sd1 <<< (amt - 4'd1)) : 22'sd0);
        q_raw = resid >>> amt;
        if (q_raw > 22'sd7)
            q = 5'sd7;
        else if (q_raw < -22'sd8)
            q = -5'sd8;
        else
            q = 5'(q_raw);
        rec_w = (23'(q) <<< amt) + 23'(pred);
        if (rec_w > 23'sd32767)
            rec = 16'sh7fff;
        else if (rec_w < -23'sd32768)
            rec = -16'sh8000;
        else
            rec = 16'(rec_w);
        d = 17'(s_cur) - 17'(rec);
        // square of the previous sample-trial's error
        sq        = 34'(d_reg * d_reg);
        err_next  = err_reg + 37'(sq);
        last_next = rec;
        prev_next = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hlast_reg <= '0;
            hprev_reg <= '0;
        end
        else if (cmd.commit)
        begin
            hlast_reg <= blast_reg;
            hprev_reg <= bprev_reg;
        end
    end

    // trial and winner registers
    always_ff @(posedge clk)
    begin
        if (cmd.trial_init)
        begin
            last_reg <= hlast_reg;
            prev_reg <= hprev_reg;
            err_reg  <= '0;
            d_reg    <= '0;
        end
        else if (cmd.run)
        begin
            last_reg <= last_next;
            prev_reg <= prev_next;
            err_reg  <= err_next;
            d_reg    <= d;
            nib_trial[cmd.smp_idx] <= 4'(q);
        end
        // err_next here includes the last sample's squared error
        if (cmd.trial_end && (err_next < werr_reg || cmd.search_init))
        begin
            werr_reg  <= err_next;
            bf_reg    <= cmd.filt;
            bs_reg    <= cmd.shft;
            blast_reg <= last_reg;
            bprev_reg <= prev_reg;
            for (int i = 0; i < NSAMP; i++)
                nib_win[i] <= nib_trial[i];
        end
    end

    // byte formation
    always_comb
    begin
        case (cmd.byte_idx)
            4'd0:    sts.byte_val = {1'b0, bf_reg, bs_reg};
            4'd1:    sts.byte_val = flags_reg;
            default: sts.byte_val = {nib_win[{cmd.byte_idx - 4'd2, 1'b1}],
                                     nib_win[{cmd.byte_idx - 4'd2, 1'b0}]};
        endcase
    end

endmodule

// ----- design/abes_ctrl.sv -----
// ----------------------------------------------------------------------------
// abes_ctrl: sequencer for collect, search and emit phases
// Walks 65 trials of 28 samples, then 16 output bytes.
// ----------------------------------------------------------------------------
module abes_ctrl
    import abes_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output abes_cmd_t cmd,
    output logic      emit_last
);

    typedef enum logic [4:0] {
        ST_COLLECT = 5'b00001,
        ST_INIT    = 5'b00010,
        ST_RUN     = 5'b00100,
        ST_END     = 5'b01000,
        ST_EMIT    = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [2:0] f_reg, f_next;
    logic [3:0] s_reg, s_next;
    logic       first_reg, first_next;
    logic [3:0] b_reg, b_next;

    assign in_ready  = (state_reg == ST_COLLECT);
    assign out_valid = (state_reg == ST_EMIT);
    assign emit_last = (b_reg == 4'(NBYTES - 1));

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        f_next     = f_reg;
        s_next     = s_reg;
        first_next = first_reg;
        b_next     = b_reg;
        cmd        = '0;
        cmd.wr_idx = cnt_reg;
        cmd.smp_idx = cnt_reg;
        cmd.filt   = f_reg;
        cmd.shft   = s_reg;
        cmd.byte_idx = b_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_valid)
                begin
                    cmd.store = 1'b1;
                    if (cnt_reg == 5'(NSAMP - 1))
                    begin
                        cnt_next   = '0;
                        f_next     = '0;
                        s_next     = '0;
                        first_next = 1'b1;
                        state_next = ST_INIT;
                    end
                    else
                        cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_INIT:
            begin
                cmd.trial_init = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                cmd.run = 1'b1;
                if (cnt_reg == 5'(NSAMP - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_END;
                end
                else
                    cnt_next = cnt_reg + 5'd1;
            end
            ST_END:
            begin
                cmd.trial_end   = 1'b1;
                cmd.search_init = first_reg;
                first_next      = 1'b0;
                if (s_reg == 4'(NSHIFT - 1))
                begin
                    s_next = '0;
                    if (f_reg == 3'(NFILT - 1))
                    begin
                        b_next     = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        f_next     = f_reg + 3'd1;
                        state_next = ST_INIT;
                    end
                end
                else
                begin
                    s_next     = s_reg + 4'd1;
                    state_next = ST_INIT;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                cmd.commit = (b_reg == 4'd0);
                if (out_ready)
                begin
                    b_next = b_reg + 4'd1;
                    if (b_reg == 4'(NBYTES - 1))
                        state_next = ST_COLLECT;
                end
            end
            default: state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_COLLECT;
            cnt_reg   <= '0;
            f_reg     <= '0;
            s_reg     <= '0;
            first_reg <= 1'b0;
            b_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            f_reg     <= f_next;
            s_reg     <= s_next;
            first_reg <= first_next;
            b_reg     <= b_next;
        end
    end

    // checks
    a_no_in_during_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_COLLECT) |-> !in_ready)
        else $error("input taken outside collect");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < 5'(NSAMP))
        else $error("sample counter out of range");
    a_emit_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_END))
        else $error("emit without search end");
    a_filt_range: assert property (@(posedge clk) disable iff (!rst_n)
        f_reg < 3'(NFILT) && s_reg < 4'(NSHIFT))
        else $error("trial pair out of range");

endmodule
